### sv/jbr_pkg.sv
// ----------------------------------------------------------------------------
// jbr_pkg
// Shared types and constants of the broadcast transport reassembler.
// ----------------------------------------------------------------------------
package jbr_pkg;

   localparam int MAX_MESSAGE_BYTES = 1785;
   localparam int MAX_PACKETS       = 255;
   localparam int LANES             = 7;
   localparam int PKT_AW            = 8;
   localparam int LANE_AW           = 3;

   localparam logic [17:0] PGN_TP_CM = 18'h00EC00;
   localparam logic [17:0] PGN_TP_DT = 18'h00EB00;
   localparam logic [7:0]  PF_PDU2   = 8'hF0;
   localparam logic [7:0]  ADDR_GLOBAL = 8'hFF;

   localparam logic [1:0] CMD_FRAME = 2'd0;
   localparam logic [1:0] CMD_TICK  = 2'd1;
   localparam logic [1:0] CMD_READ  = 2'd2;

   localparam logic [2:0] ST_NONE     = 3'd0;
   localparam logic [2:0] ST_PROTOCOL = 3'd1;
   localparam logic [2:0] ST_PLAIN    = 3'd2;
   localparam logic [2:0] ST_COMPLETE = 3'd3;
   localparam logic [2:0] ST_TIMEOUT  = 3'd4;

   localparam logic [7:0] CSR_FIRST_TIMEOUT = 8'd0;
   localparam logic [7:0] CSR_NEXT_TIMEOUT  = 8'd1;

   // seen-tag epochs: zero marks a packet never seen
   localparam logic [7:0] EPOCH_NONE  = 8'd0;
   localparam logic [7:0] EPOCH_FIRST = 8'd1;
   localparam logic [7:0] EPOCH_LAST  = 8'd255;

   typedef struct packed {
      logic [1:0]  command;
      logic [28:0] can_id;
      logic [3:0]  frame_length;
      logic [63:0] frame_data;
      logic [10:0] read_index;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [2:0]  priority_res;
      logic [17:0] pgn;
      logic [7:0]  dest_addr;
      logic [7:0]  src_addr;
      logic [10:0] message_length;
      logic [63:0] payload;
      logic [7:0]  read_byte;
   } rsp_type;

   typedef struct packed {
      logic              we;
      logic [PKT_AW-1:0] waddr;
      logic [10:0]       offset;
      logic [10:0]       size;
      logic              re;
      logic [PKT_AW-1:0] raddr;
   } lane_ctl_type;

endpackage

### sv/j1939_bam_reassembler_core.sv
// ----------------------------------------------------------------------------
// j1939_bam_reassembler_core
// Broadcast transport reassembler: decodes frames, tracks one BAM transfer,
// stores data packets into seven byte-lane RAMs and serves buffer reads.
// ----------------------------------------------------------------------------
// Every beat produces exactly one result beat. Ticks, reads and frames other
// than data packets return their result in the cycle after acceptance, and
// a new beat is accepted each cycle unless a result is held by rsp_stall, a
// data packet is pending or a clearing pass runs. A data packet's accept
// cycle writes its seven payload bytes in parallel, one per lane RAM (lane k
// holds byte k of each packet), and reads its packet-seen tag; a pending
// state then counts the packet, updates the transfer and loads the result.
// Packet-seen flags live in a tag RAM: each entry holds the transfer epoch
// in which that packet arrived, and an accepted BAM advances the epoch
// instead of clearing flags. A clearing pass writes every tag to zero after
// reset and again at every 255th accepted BAM, when the epoch wraps; the
// input stalls during the pass. A read splits the index into packet and
// lane with a reciprocal multiply, reads all lanes and the merge stage picks
// the lane byte on the output. CSR writes are always ready.
// ----------------------------------------------------------------------------
module j1939_bam_reassembler_core
   import jbr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   // configuration
   logic [15:0] t1_ff, t3_ff;

   // transfer state
   logic              active_ff, active_in;
   logic [7:0]        sender_ff, sender_in;
   logic [17:0]       tpgn_ff, tpgn_in;
   logic [10:0]       tsize_ff, tsize_in;
   logic [7:0]        expected_ff, expected_in;
   logic [7:0]        received_ff, received_in;
   logic [15:0]       left_ff, left_in;
   logic [7:0]        epoch_ff, epoch_in;

   // data packet waiting for its seen tag
   logic              pend_ff;
   logic              pend_ok_ff;
   logic [PKT_AW-1:0] pend_idx_ff;

   // seen-tag clearing pass
   logic              clr_ff;
   logic [PKT_AW-1:0] clr_addr_ff;

   // output stage
   logic              rsp_valid_ff;
   rsp_type           rsp_ff, rsp_in;
   logic [LANE_AW-1:0] rlane_ff;
   logic              rzero_ff;

   logic accept;
   assign req_stall = pend_ff || clr_ff || (rsp_valid_ff && rsp_stall);
   assign accept    = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   // header decode
   logic [17:0] pgn_raw, pgn;
   logic [7:0]  src, dest;
   logic        pdu1;
   assign pgn_raw = req_data.can_id[25:8];
   assign src     = req_data.can_id[7:0];
   assign pdu1    = pgn_raw[15:8] < PF_PDU2;
   assign dest    = pdu1 ? pgn_raw[7:0] : ADDR_GLOBAL;
   assign pgn     = pdu1 ? {pgn_raw[17:8], 8'h00} : pgn_raw;

   // BAM fields
   logic [15:0] bam_size;
   logic [7:0]  bam_npk;
   assign bam_size = req_data.frame_data[23:8];
   assign bam_npk  = req_data.frame_data[31:24];

   // data packet fields
   logic [7:0]  seq, seq_idx;
   logic        dt_ok, was_seen;
   logic [7:0]  new_count;
   logic [10:0] pkt_offset;
   logic [7:0]  tag_rdata;
   assign seq        = req_data.frame_data[7:0];
   assign seq_idx    = seq - 8'd1;
   assign dt_ok      = active_ff && (src == sender_ff) && (seq != 8'd0)
                       && (seq <= expected_ff);
   // a tag from the current epoch means the packet came in already
   assign was_seen   = tag_rdata == epoch_ff;
   assign new_count  = received_ff + {7'd0, !was_seen};
   // (seq-1)*7 as shift and subtract
   assign pkt_offset = {seq_idx, 3'd0} - {3'd0, seq_idx};

   // read index split: q = idx/7, r = idx%7
   logic [23:0] rq_prod;
   logic [7:0]  rq;
   logic [10:0] rq_x7;
   logic [10:0] rrem;
   assign rq_prod = {13'd0, req_data.read_index} * 24'd4682;
   assign rq      = rq_prod[22:15];
   assign rq_x7   = {rq, 3'd0} - {3'd0, rq};
   assign rrem    = req_data.read_index - rq_x7;

   logic is_frame, is_bam, is_dt, is_read, bam_take, clr_start;
   assign is_frame  = req_data.command == CMD_FRAME;
   assign is_bam    = is_frame && (pgn == PGN_TP_CM);
   assign is_dt     = is_frame && (pgn == PGN_TP_DT);
   assign is_read   = req_data.command == CMD_READ;
   assign bam_take  = is_bam && (bam_size <= 16'(MAX_MESSAGE_BYTES));
   assign clr_start = accept && bam_take && (epoch_ff == EPOCH_LAST);

   always_comb begin
      active_in   = active_ff;
      sender_in   = sender_ff;
      tpgn_in     = tpgn_ff;
      tsize_in    = tsize_ff;
      expected_in = expected_ff;
      received_in = received_ff;
      left_in     = left_ff;
      epoch_in    = epoch_ff;
      rsp_in      = '0;
      if (pend_ff) begin
         // finish the data packet; rsp_ff holds its decoded header
         rsp_in = rsp_ff;
         if (pend_ok_ff) begin
            received_in = new_count;
            if (new_count == expected_ff) begin
               active_in             = 1'b0;
               rsp_in.status         = ST_COMPLETE;
               rsp_in.pgn            = tpgn_ff;
               rsp_in.message_length = tsize_ff;
            end else begin
               left_in       = t3_ff;
               rsp_in.status = ST_PROTOCOL;
            end
         end
      end else begin
         case (req_data.command)
            CMD_TICK: begin
               if (active_ff) begin
                  if (left_ff == 16'd0) begin
                     // discard the stalled transfer
                     active_in             = 1'b0;
                     received_in           = 8'd0;
                     rsp_in.status         = ST_TIMEOUT;
                     rsp_in.pgn            = tpgn_ff;
                     rsp_in.dest_addr      = ADDR_GLOBAL;
                     rsp_in.src_addr       = sender_ff;
                     rsp_in.message_length = tsize_ff;
                  end else begin
                     left_in = left_ff - 16'd1;
                  end
               end
            end
            CMD_FRAME: begin
               rsp_in.priority_res   = req_data.can_id[28:26];
               rsp_in.pgn            = pgn;
               rsp_in.dest_addr      = dest;
               rsp_in.src_addr       = src;
               rsp_in.message_length = {7'd0, req_data.frame_length};
               if (is_bam) begin
                  // drop oversized announcements, else open a transfer
                  if (bam_take) begin
                     tpgn_in       = req_data.frame_data[57:40];
                     sender_in     = src;
                     tsize_in      = bam_size[10:0];
                     expected_in   = bam_npk;
                     received_in   = 8'd0;
                     epoch_in      = (epoch_ff == EPOCH_LAST) ? EPOCH_FIRST
                                                              : epoch_ff + 8'd1;
                     left_in       = t1_ff;
                     active_in     = 1'b1;
                     rsp_in.status = ST_PROTOCOL;
                  end
               end else if (is_dt) begin
                  // hold the header; advance the transfer once the tag is back
                  rsp_in.status = ST_NONE;
               end else begin
                  rsp_in.status  = ST_PLAIN;
                  rsp_in.payload = req_data.frame_data;
               end
            end
            default: begin
               rsp_in = '0;
            end
         endcase
      end
   end

   // packet-seen tags, one per sequence number
   logic              tag_we;
   logic [PKT_AW-1:0] tag_waddr;
   logic [7:0]        tag_wdata;
   assign tag_we    = clr_ff || (pend_ff && pend_ok_ff);
   assign tag_waddr = clr_ff ? clr_addr_ff : pend_idx_ff;
   assign tag_wdata = clr_ff ? EPOCH_NONE : epoch_ff;

   jbr_ram #(
      .WIDTH(8),
      .DEPTH(MAX_PACKETS)
   ) u_seen_ram (
      .clock(clock),
      .we   (tag_we),
      .waddr(tag_waddr),
      .wdata(tag_wdata),
      .re   (accept && is_dt),
      .raddr(seq_idx),
      .rdata(tag_rdata)
   );

   // lane control shared by all seven lanes
   lane_ctl_type lane_ctl;
   assign lane_ctl.we     = accept && is_dt && dt_ok;
   assign lane_ctl.waddr  = seq_idx;
   assign lane_ctl.offset = pkt_offset;
   assign lane_ctl.size   = tsize_ff;
   assign lane_ctl.re     = accept && is_read;
   assign lane_ctl.raddr  = rq;

   logic [7:0] lane_rdata [LANES];

   for (genvar g = 0; g < LANES; g++) begin : g_lane
      jbr_lane u_lane (
         .clock  (clock),
         .lane_id(LANE_AW'(g)),
         .ctl    (lane_ctl),
         .wdata  (req_data.frame_data[8*g+15 -: 8]),
         .rdata  (lane_rdata[g])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         t1_ff        <= 16'd750;
         t3_ff        <= 16'd1250;
         active_ff    <= 1'b0;
         sender_ff    <= 8'd0;
         tpgn_ff      <= 18'd0;
         tsize_ff     <= 11'd0;
         expected_ff  <= 8'd0;
         received_ff  <= 8'd0;
         left_ff      <= 16'd0;
         epoch_ff     <= EPOCH_FIRST;
         pend_ff      <= 1'b0;
         clr_ff       <= 1'b1;
         clr_addr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_FIRST_TIMEOUT) begin
               t1_ff <= csr_wdata;
            end else if (csr_index == CSR_NEXT_TIMEOUT) begin
               t3_ff <= csr_wdata;
            end
         end
         if (accept || pend_ff) begin
            active_ff    <= active_in;
            sender_ff    <= sender_in;
            tpgn_ff      <= tpgn_in;
            tsize_ff     <= tsize_in;
            expected_ff  <= expected_in;
            received_ff  <= received_in;
            left_ff      <= left_in;
            epoch_ff     <= epoch_in;
         end
         if (accept) begin
            // a data packet waits in the pending state for its tag
            rsp_valid_ff <= !is_dt;
            pend_ff      <= is_dt;
         end else if (pend_ff) begin
            rsp_valid_ff <= 1'b1;
            pend_ff      <= 1'b0;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         // sweep all tags back to never seen
         if (clr_ff) begin
            clr_addr_ff <= clr_addr_ff + PKT_AW'(1);
            if (clr_addr_ff == PKT_AW'(MAX_PACKETS - 1)) begin
               clr_ff <= 1'b0;
            end
         end else if (clr_start) begin
            clr_ff      <= 1'b1;
            clr_addr_ff <= '0;
         end
      end
   end

   // result payload; hold while stalled
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff      <= rsp_in;
         rlane_ff    <= rrem[LANE_AW-1:0];
         rzero_ff    <= !is_read || (req_data.read_index >= 11'(MAX_MESSAGE_BYTES));
         pend_ok_ff  <= dt_ok;
         pend_idx_ff <= seq_idx;
      end else if (pend_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   // merge: pick the addressed lane's byte
   logic [7:0] merged_byte;
   always_comb begin
      merged_byte = 8'd0;
      for (int i = 0; i < LANES; i++) begin
         if (rlane_ff == LANE_AW'(i)) begin
            merged_byte = lane_rdata[i];
         end
      end
   end

   always_comb begin
      rsp_data           = rsp_ff;
      rsp_data.read_byte = rzero_ff ? 8'd0 : merged_byte;
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

### sv/jbr_ram.sv
// ----------------------------------------------------------------------------
// jbr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module jbr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

### sv/jbr_lane.sv
// ----------------------------------------------------------------------------
// jbr_lane
// One byte lane of the message buffer: stores byte lane_id of every packet,
// dropping bytes past the announced message size.
// ----------------------------------------------------------------------------
module jbr_lane
   import jbr_pkg::*;
(
   input  logic         clock,
   input  logic [2:0]   lane_id,
   input  lane_ctl_type ctl,
   input  logic [7:0]   wdata,
   output logic [7:0]   rdata
);

   logic [10:0] pos;
   logic        lane_we;

   // byte position of this lane inside the message
   assign pos     = ctl.offset + {8'd0, lane_id};
   assign lane_we = ctl.we && (pos < ctl.size);

   jbr_ram #(
      .WIDTH(8),
      .DEPTH(MAX_PACKETS)
   ) u_ram (
      .clock(clock),
      .we   (lane_we),
      .waddr(ctl.waddr),
      .wdata(wdata),
      .re   (ctl.re),
      .raddr(ctl.raddr),
      .rdata(rdata)
   );

endmodule

### dv/j1939_bam_reassembler_core_tb.sv
// ----------------------------------------------------------------------------
// j1939_bam_reassembler_core_tb
// Self-checking bench for the broadcast transport reassembler: a directed
// table of frames, ticks and reads, then random BAM transfers with noise,
// all checked beat by beat against a behavioral model of the block.
// ----------------------------------------------------------------------------
module j1939_bam_reassembler_core_tb;
   import jbr_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_ITEMS = 1250;
   localparam int CYCLE_LIMIT  = 400000;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_stall;
   rsp_type     rsp_data;
   logic        csr_valid;
   logic        csr_ready;
   logic [7:0]  csr_index;
   logic [15:0] csr_wdata;

   j1939_bam_reassembler_core uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   // ------------------------------------------------------------------------
   // Shadow copy of the reassembler state
   // ------------------------------------------------------------------------
   logic [15:0] t1_budget;
   logic [15:0] t3_budget;
   logic        xfer_open;
   logic [7:0]  xfer_src;
   logic [17:0] xfer_pgn;
   logic [10:0] xfer_size;
   logic [7:0]  pkts_total;
   logic [7:0]  pkts_got;
   logic        pkt_done [MAX_PACKETS];
   logic [7:0]  msg_bytes [MAX_MESSAGE_BYTES];
   logic        msg_written [MAX_MESSAGE_BYTES];
   logic [15:0] ticks_left;

   rsp_type     rsp_expected_q [$];
   int          mismatch_count;
   int          cycle_count;
   int          rsp_count;
   int          complete_count;
   int          timeout_count;

   function automatic rsp_type decode_beat(req_type r);
      rsp_type     o;
      logic [17:0] pg;
      logic [7:0]  dst;
      logic [10:0] sz;
      logic [7:0]  npk;
      logic [7:0]  seq;
      int          off;
      o = '0;
      if (r.command == CMD_TICK) begin
         if (xfer_open) begin
            if (ticks_left == 16'd0) begin
               xfer_open = 1'b0;
               pkts_got = 8'd0;
               o.status = ST_TIMEOUT;
               o.pgn = xfer_pgn;
               o.dest_addr = ADDR_GLOBAL;
               o.src_addr = xfer_src;
               o.message_length = xfer_size;
            end else begin
               ticks_left = ticks_left - 16'd1;
            end
         end
         return o;
      end
      if (r.command == CMD_READ) begin
         if (r.read_index < MAX_MESSAGE_BYTES)
            o.read_byte = msg_bytes[r.read_index];
         return o;
      end
      if (r.command != CMD_FRAME)
         return o;

      pg = r.can_id[25:8];
      if (pg[15:8] < PF_PDU2) begin
         dst = pg[7:0];
         pg[7:0] = 8'h00;
      end else begin
         dst = ADDR_GLOBAL;
      end
      o.priority_res = r.can_id[28:26];
      o.pgn = pg;
      o.dest_addr = dst;
      o.src_addr = r.can_id[7:0];
      o.message_length = {7'd0, r.frame_length};

      if (pg == PGN_TP_CM) begin
         if (r.frame_data[23:8] > MAX_MESSAGE_BYTES) return o;
         sz = r.frame_data[18:8];
         npk = r.frame_data[31:24];
         xfer_pgn = r.frame_data[57:40];
         xfer_src = r.can_id[7:0];
         xfer_size = sz;
         pkts_total = npk;
         pkts_got = 8'd0;
         foreach (pkt_done[i]) pkt_done[i] = 1'b0;
         ticks_left = t1_budget;
         xfer_open = 1'b1;
         o.status = ST_PROTOCOL;
         return o;
      end
      if (pg == PGN_TP_DT) begin
         seq = r.frame_data[7:0];
         if (!xfer_open || r.can_id[7:0] != xfer_src) return o;
         if (seq < 8'd1 || seq > pkts_total) return o;
         off = (int'(seq) - 1) * 7;
         for (int k = 0; k < 7; k++) begin
            if (off + k < int'(xfer_size) && off + k < MAX_MESSAGE_BYTES) begin
               msg_bytes[off + k] = r.frame_data[8*(k+1) +: 8];
               msg_written[off + k] = 1'b1;
            end
         end
         if (!pkt_done[seq - 1]) begin
            pkt_done[seq - 1] = 1'b1;
            pkts_got = pkts_got + 8'd1;
         end
         if (pkts_got == pkts_total) begin
            xfer_open = 1'b0;
            o.status = ST_COMPLETE;
            o.pgn = xfer_pgn;
            o.dest_addr = dst;
            o.message_length = xfer_size;
            // dest and src stay the decoded header; only pgn/size change
            return o;
         end
         ticks_left = t3_budget;
         o.status = ST_PROTOCOL;
         return o;
      end
      o.status = ST_PLAIN;
      o.payload = r.frame_data;
      return o;
   endfunction

   // ------------------------------------------------------------------------
   // Beat builders
   // ------------------------------------------------------------------------
   function automatic req_type mk_frame(logic [28:0] id, logic [3:0] len,
                                        logic [63:0] d);
      req_type r;
      r = '0;
      r.command = CMD_FRAME;
      r.can_id = id;
      r.frame_length = len;
      r.frame_data = d;
      return r;
   endfunction

   function automatic req_type mk_cmd(logic [1:0] c, logic [10:0] idx);
      req_type r;
      r = '0;
      r.command = c;
      r.read_index = idx;
      return r;
   endfunction

   function automatic logic [28:0] mk_id(logic [2:0] p, logic [17:0] pg,
                                         logic [7:0] sa);
      return {p, pg, sa};
   endfunction

   function automatic logic [63:0] mk_bam(logic [15:0] sz, logic [7:0] n,
                                          logic [17:0] pg);
      return {6'd0, pg, 8'hFF, n, sz, 8'h20};
   endfunction

   // ------------------------------------------------------------------------
   // Driver: bursts with random gaps, waits on the handshake
   // ------------------------------------------------------------------------
   int  burst_left;
   bit  hold_gaps;

   task automatic send_beat(req_type r, bit has_fixed, rsp_type fixed);
      rsp_type e;
      int      gap;
      if (!hold_gaps) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 20);
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
               req_valid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
         burst_left--;
      end
      req_valid <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      e = decode_beat(r);
      if (has_fixed && e != fixed) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("table row disagrees with model: row %h model %h", fixed, e);
      end
      rsp_expected_q.push_back(e);
   endtask

   task automatic wait_drain();
      req_valid <= 1'b0;
      while (rsp_expected_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(logic [7:0] idx, logic [15:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      if (idx == CSR_FIRST_TIMEOUT) t1_budget = val;
      else if (idx == CSR_NEXT_TIMEOUT) t3_budget = val;
      @(posedge clock);
   endtask

   // ------------------------------------------------------------------------
   // Receiver: stall pattern plus one long hold-off
   // ------------------------------------------------------------------------
   bit long_hold_req;
   int stall_mode;

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (long_hold_req) begin
         rsp_stall <= 1'b1;
      end else begin
         case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 3) == 0);
            default: rsp_stall <= ($urandom_range(0, 1) == 0);
         endcase
      end
   end

   always @(posedge clock) begin
      if (!reset && ($urandom_range(0, 199) == 0))
         stall_mode <= $urandom_range(0, 2);
   end

   // Check every accepted result beat against the oldest expectation.
   always @(posedge clock) begin
      rsp_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         rsp_count++;
         if (rsp_expected_q.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected result beat %h", rsp_data);
         end else begin
            e = rsp_expected_q.pop_front();
            if (e.status == ST_COMPLETE) complete_count++;
            if (e.status == ST_TIMEOUT) timeout_count++;
            if (rsp_data.status != e.status || rsp_data.priority_res != e.priority_res ||
                rsp_data.pgn != e.pgn || rsp_data.dest_addr != e.dest_addr ||
                rsp_data.src_addr != e.src_addr ||
                rsp_data.message_length != e.message_length ||
                rsp_data.payload != e.payload || rsp_data.read_byte != e.read_byte) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("result mismatch: expected %h actual %h", e, rsp_data);
            end
         end
      end
   end

   // Bound the run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Directed table
   // ------------------------------------------------------------------------
   typedef struct {
      req_type r;
      bit      has_fixed;
      rsp_type fixed;
   } row_type;

   row_type dir_rows [$];

   task automatic add_row(req_type r, bit hf, rsp_type f);
      row_type w;
      w.r = r;
      w.has_fixed = hf;
      w.fixed = f;
      dir_rows.push_back(w);
   endtask

   task automatic build_table();
      rsp_type f;
      // idle tick
      f = '0;
      add_row(mk_cmd(CMD_TICK, 11'd0), 1, f);
      // unknown command
      add_row(mk_cmd(2'd3, 11'h7FF), 1, f);
      // read beyond buffer
      add_row(mk_cmd(CMD_READ, 11'h7FF), 1, f);
      // plain PDU2 frame, all ones
      f = '0;
      f.status = ST_PLAIN; f.priority_res = 3'd7; f.pgn = 18'h3FFFF;
      f.dest_addr = 8'hFF; f.src_addr = 8'hFF; f.message_length = 11'd15;
      f.payload = '1;
      add_row(mk_frame('1, 4'hF, '1), 1, f);
      // plain frame, all zeros: PDU1 with dest 0
      f = '0;
      f.status = ST_PLAIN;
      add_row(mk_frame('0, 4'd0, '0), 1, f);
      // an oversized BAM, then a 14-byte BAM of 255 packets from the same sender
      f = '0;
      f.pgn = PGN_TP_CM; f.dest_addr = 8'hFF; f.src_addr = 8'h11;
      f.message_length = 11'd8;
      add_row(mk_frame(mk_id(3'd0, 18'h0ECFF, 8'h11), 4'd8,
                       mk_bam(16'd1786, 8'd255, 18'h1234)), 1, f);
      add_row(mk_frame(mk_id(3'd0, 18'h0ECFF, 8'h11), 4'd8,
                       {24'd0, 8'd0, 8'hFF, 16'd14, 8'h20}), 0, f);
      // stray data packet from a sender with no open transfer
      f = '0;
      f.pgn = PGN_TP_DT; f.dest_addr = 8'hFF; f.src_addr = 8'h22;
      f.message_length = 11'd8;
      add_row(mk_frame(mk_id(3'd0, 18'h0EBFF, 8'h22), 4'd8, 64'h01), 1, f);
      // EDP-set max-size BAM (a plain frame), then one with a two-byte tail
      add_row(mk_frame(mk_id(3'd6, 18'h2ECFF, 8'h33), 4'd8,
                       mk_bam(16'd1785, 8'd255, 18'h3FEFE)), 0, f);
      add_row(mk_frame(mk_id(3'd6, 18'h0ECFF, 8'h33), 4'd8,
                       mk_bam(16'd9, 8'd2, 18'h3FEFE)), 0, f);
      add_row(mk_frame(mk_id(3'd0, 18'h0EB00, 8'h34), 4'd8,
                       64'hAAAAAAAAAAAAAA01), 0, f);
      add_row(mk_frame(mk_id(3'd0, 18'h0EB00, 8'h33), 4'd8,
                       64'h0706050403020100), 0, f);
      add_row(mk_frame(mk_id(3'd0, 18'h0EB00, 8'h33), 4'd8,
                       64'h0706050403020103), 0, f);
      add_row(mk_frame(mk_id(3'd0, 18'h0EB00, 8'h33), 4'd8,
                       64'h0706050403020101), 0, f);
      add_row(mk_frame(mk_id(3'd0, 18'h0EB00, 8'h33), 4'd8,
                       64'h0706050403020101), 0, f);
      add_row(mk_frame(mk_id(3'd0, 18'h0EB00, 8'h33), 4'd8,
                       64'hF0E0D0C0B0A09002), 0, f);
      add_row(mk_cmd(CMD_READ, 11'd8), 0, f);
      add_row(mk_cmd(CMD_READ, 11'd0), 0, f);
      // zero-packet BAM, then ticks run out
      add_row(mk_frame(mk_id(3'd3, 18'h0ECFF, 8'h44), 4'd8,
                       mk_bam(16'd0, 8'd0, 18'h0FECA)), 0, f);
      add_row(mk_cmd(CMD_TICK, 11'd0), 0, f);
      add_row(mk_cmd(CMD_TICK, 11'd0), 0, f);
   endtask

   // ------------------------------------------------------------------------
   // Random traffic
   // ------------------------------------------------------------------------
   int rand_sent;

   task automatic send_random_noise();
      req_type r;
      int      sel;
      sel = $urandom_range(0, 5);
      r = '0;
      r.command = 2'($urandom_range(0, 3));
      r.can_id = 29'($urandom);
      r.frame_length = 4'($urandom);
      r.frame_data = {$urandom, $urandom};
      r.read_index = 11'($urandom);
      if (sel == 0) r.read_index = 11'($urandom_range(0, 40));
      if (r.command == CMD_READ && r.read_index < MAX_MESSAGE_BYTES &&
          !msg_written[r.read_index])
         r.read_index = 11'h7FF;
      send_beat(r, 0, '0);
      rand_sent++;
   endtask

   task automatic send_random_transfer();
      logic [7:0]  sa;
      logic [2:0]  pr;
      logic [10:0] sz;
      int          npk;
      int          order [$];
      logic [63:0] d;
      logic [17:0] cm;
      logic [17:0] dt;
      logic [10:0] ridx;
      sa = 8'($urandom);
      pr = 3'($urandom);
      sz = ($urandom_range(0, 15) == 0) ? 11'd1785 : 11'($urandom_range(0, 60));
      npk = (int'(sz) + 6) / 7;
      if ($urandom_range(0, 7) == 0) npk = $urandom_range(0, 10);
      // pick a TP.CM/TP.DT identifier; PS byte random, DP/EDP clear on PDU1
      cm = {2'($urandom_range(0, 3)), 8'hEC, 8'($urandom)};
      dt = {2'b00, 8'hEB, 8'($urandom)};
      d = mk_bam({5'd0, sz}, 8'(npk), 18'($urandom));
      d[7:0] = 8'($urandom);
      send_beat(mk_frame(mk_id(pr, {2'b00, cm[15:0]}, sa), 4'($urandom), d), 0, '0);
      rand_sent++;
      for (int i = 1; i <= npk; i++) order.push_back(i);
      order.shuffle();
      if ($urandom_range(0, 3) == 0 && npk > 0) order.push_back($urandom_range(1, npk));
      if ($urandom_range(0, 5) == 0 && order.size() > 0) void'(order.pop_back());
      foreach (order[i]) begin
         if ($urandom_range(0, 9) == 0) send_random_noise();
         if ($urandom_range(0, 6) == 0) begin
            send_beat(mk_cmd(CMD_TICK, 11'd0), 0, '0);
            rand_sent++;
         end
         d = {$urandom, $urandom};
         d[7:0] = 8'(order[i]);
         if ($urandom_range(0, 20) == 0) d[7:0] = 8'($urandom);
         send_beat(mk_frame(mk_id(3'($urandom), dt,
                   ($urandom_range(0, 20) == 0) ? 8'($urandom) : sa), 4'd8, d), 0, '0);
         rand_sent++;
      end
      repeat ($urandom_range(0, 3)) begin
         ridx = 11'($urandom_range(0, sz));
         if (ridx >= MAX_MESSAGE_BYTES || !msg_written[ridx]) ridx = 11'h7FF;
         send_beat(mk_cmd(CMD_READ, ridx), 0, '0);
         rand_sent++;
      end
      if ($urandom_range(0, 4) == 0) begin
         repeat ($urandom_range(1, 8)) begin
            send_beat(mk_cmd(CMD_TICK, 11'd0), 0, '0);
            rand_sent++;
         end
      end
   endtask

   // ------------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------------
   initial begin
      logic [15:0] t1_set [4];
      logic [15:0] t3_set [4];
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      long_hold_req = 1'b0;
      stall_mode = 0;
      burst_left = 0;
      hold_gaps = 1'b0;
      mismatch_count = 0;
      cycle_count = 0;
      rsp_count = 0;
      complete_count = 0;
      timeout_count = 0;
      rand_sent = 0;
      t1_budget = 16'd750;
      t3_budget = 16'd1250;
      xfer_open = 1'b0;
      xfer_src = '0;
      xfer_pgn = '0;
      xfer_size = '0;
      pkts_total = '0;
      pkts_got = '0;
      ticks_left = '0;
      foreach (pkt_done[i]) pkt_done[i] = 1'b0;
      foreach (msg_bytes[i]) begin
         msg_bytes[i] = 8'h00;
         msg_written[i] = 1'b0;
      end
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part at budgets of one tick so the zero-packet BAM times out.
      write_csr(CSR_FIRST_TIMEOUT, 16'd1);
      write_csr(CSR_NEXT_TIMEOUT, 16'd1);
      build_table();
      foreach (dir_rows[i]) send_beat(dir_rows[i].r, dir_rows[i].has_fixed,
                                      dir_rows[i].fixed);
      wait_drain();

      // Pressure: hold the receiver off and keep offering beats.
      long_hold_req <= 1'b1;
      hold_gaps = 1'b1;
      fork
         begin
            repeat (300) @(posedge clock);
            long_hold_req <= 1'b0;
         end
         repeat (40) send_random_noise();
      join
      hold_gaps = 1'b0;
      wait_drain();

      t1_set = '{16'd2, 16'hFFFF, 16'd750, 16'd5};
      t3_set = '{16'd3, 16'hFFFF, 16'd1250, 16'd1};
      for (int ph = 0; ph < 4; ph++) begin
         write_csr(CSR_FIRST_TIMEOUT, t1_set[ph]);
         write_csr(CSR_NEXT_TIMEOUT, t3_set[ph]);
         while (rand_sent < (RANDOM_ITEMS * (ph + 1)) / 4) begin
            if ($urandom_range(0, 4) == 0) send_random_noise();
            else send_random_transfer();
         end
         wait_drain();
      end

      repeat (20) @(posedge clock);
      $display("covered %0d result beats: %0d completed transfers, %0d timeouts",
               rsp_count, complete_count, timeout_count);
      $display("timeout budgets swept from 1 to 65535 ticks, %0d mismatches",
               mismatch_count);
      if (mismatch_count == 0 && rsp_expected_q.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
